FILE: hdl/pefp_pkg.sv
package pefp_pkg;

  // Bit length of the largest normal magnitude after the common shift.
  localparam int unsigned NORM_BITS  = 30;
  // Root of a sum of three squares of NORM_BITS-bit values.
  localparam int unsigned ROOT_W     = NORM_BITS + 1;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  // Radicand and working root width of the digit-by-digit square root.
  localparam int unsigned SQ_W       = 2 * NORM_BITS + 3;
  // Fraction bits of the coordinates.
  localparam int unsigned COORD_FRAC = 8;

endpackage

FILE: hdl/plane_equation_from_points.sv
// Plane equation from three points, one triangle per clock while the output is not stalled.
// Input stream: s_axis_* carries the nine coordinates p1..p3 (x, y, z each),
// counter-clockwise, signed with 8 fraction bits. A transaction is taken
// whenever tvalid and tready are both high.
// Output stream: m_axis_* carries the unit normal (NORMAL_FRAC_BITS fraction
// bits) and the plane offset (8 fraction bits); tuser flags collinear points,
// in which case every data field is zero.
// The pipeline has 3 + clog2(max(2*COORD_WIDTH+2, 30)) + 2 + 31 + 1 +
// (NORMAL_FRAC_BITS + 2) + 4 register stages; with the defaults that is
// 63 stages. The stage count follows from the bit-per-stage square root
// and the bit-per-stage dividers for the three components.
// Throughput: one transaction per cycle while the receiver keeps up.
// A skid register behind the last stage catches a result the receiver
// stalls; while it is full the pipeline holds and s_axis_tready_o is low,
// so nothing is lost or repeated. s_axis_tready_o comes from a register.
// Reset clears all valid bits, including that of the skid register; no clearing pass.
module plane_equation_from_points #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, zero padding
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // normal_x, normal_y, normal_z, plane_offset, zero padding
  output logic [((3*(NORMAL_FRAC_BITS+2)+COORD_WIDTH+8+7)/8)*8-1:0] m_axis_tdata_o,
  // degenerate
  output logic m_axis_tuser_o
);
  import pefp_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned NF   = NORMAL_FRAC_BITS;
  localparam int unsigned NWD  = NF + 2;
  localparam int unsigned OW   = CW + COORD_FRAC;
  localparam int unsigned OD   = 3*NWD + OW;
  localparam int unsigned OTW  = ((OD+7)/8)*8;
  localparam int unsigned NW   = (2*CW+2 > NORM_BITS) ? 2*CW+2 : NORM_BITS;
  localparam int unsigned NL   = $clog2(NW);
  localparam int unsigned QW   = NF + 2;
  localparam int unsigned DW   = NORM_BITS + NF + 1;
  localparam int unsigned RW   = ROOT_W;
  localparam int unsigned AW   = NWD + CW + 2;
  localparam int unsigned EW   = AW + 1;

  localparam int unsigned ST_EDGE  = 0;
  localparam int unsigned ST_PROD  = 1;
  localparam int unsigned ST_CROSS = 2;
  localparam int unsigned ST_NORM  = 3;
  localparam int unsigned ST_SQ    = ST_NORM + NL;
  localparam int unsigned ST_SUM   = ST_SQ + 1;
  localparam int unsigned ST_SQRT  = ST_SUM + 1;
  localparam int unsigned ST_DIV0  = ST_SQRT + SQRT_STEPS;
  localparam int unsigned ST_DIV   = ST_DIV0 + 1;
  localparam int unsigned ST_CLAMP = ST_DIV + QW;
  localparam int unsigned ST_OPROD = ST_CLAMP + 1;
  localparam int unsigned ST_OSUM  = ST_OPROD + 1;
  localparam int unsigned ST_FIN   = ST_OSUM + 1;
  localparam int unsigned NST      = ST_FIN + 1;

  typedef struct packed {
    logic                        deg;
    logic [2:0][CW-1:0]          p3;
    logic [2:0][CW:0]            u;
    logic [2:0][CW:0]            v;
    logic [2:0][2*CW+1:0]        pa;
    logic [2:0][2*CW+1:0]        pb;
    logic [2:0]                  neg;
    logic [2:0][NW-1:0]          mag;
    logic [NW-1:0]               orw;
    logic [2:0][2*NORM_BITS-1:0] sq;
    logic [SQ_W-1:0]             x;
    logic [SQ_W-1:0]             r;
    logic [2:0][RW-1:0]          rem;
    logic [2:0][QW-1:0]          nlow;
    logic [2:0][NWD-1:0]         nu;
    logic [2:0][NWD+CW-1:0]      prod;
    logic [AW-1:0]               acc;
    logic [OW-1:0]               off;
  } pipe_t;

  pipe_t pipe_d [NST];
  pipe_t pipe_q [NST];
  logic [NST-1:0] vld_q;

  logic           en;
  logic           skid_vq;
  logic [OTW:0]   skid_q;
  logic [OTW:0]   last_word;

  assign en = ~skid_vq;
  assign s_axis_tready_o = en;

  // edges
  always_comb begin
    logic [CW-1:0] c [9];
    pipe_d[ST_EDGE] = pipe_q[ST_EDGE];
    for (int k = 0; k < 9; k++) begin
      c[k] = s_axis_tdata_i[k*CW +: CW];
    end
    for (int i = 0; i < 3; i++) begin
      pipe_d[ST_EDGE].u[i] = {c[3+i][CW-1], c[3+i]} - {c[i][CW-1], c[i]};
      pipe_d[ST_EDGE].v[i] = {c[6+i][CW-1], c[6+i]} - {c[i][CW-1], c[i]};
      pipe_d[ST_EDGE].p3[i] = c[6+i];
    end
  end

  // cross product terms
  always_comb begin
    pipe_t pr;
    pr = pipe_q[ST_PROD-1];
    pipe_d[ST_PROD] = pr;
    pipe_d[ST_PROD].pa[0] = $signed(pr.u[1]) * $signed(pr.v[2]);
    pipe_d[ST_PROD].pb[0] = $signed(pr.v[1]) * $signed(pr.u[2]);
    pipe_d[ST_PROD].pa[1] = $signed(pr.v[0]) * $signed(pr.u[2]);
    pipe_d[ST_PROD].pb[1] = $signed(pr.u[0]) * $signed(pr.v[2]);
    pipe_d[ST_PROD].pa[2] = $signed(pr.u[0]) * $signed(pr.v[1]);
    pipe_d[ST_PROD].pb[2] = $signed(pr.v[0]) * $signed(pr.u[1]);
  end

  always_comb begin
    pipe_t pr;
    logic [2*CW+2:0] n;
    logic [2*CW+2:0] a;
    logic [NW-1:0]   o;
    pr = pipe_q[ST_CROSS-1];
    pipe_d[ST_CROSS] = pr;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      n = {pr.pa[i][2*CW+1], pr.pa[i]} - {pr.pb[i][2*CW+1], pr.pb[i]};
      a = n[2*CW+2] ? -n : n;
      pipe_d[ST_CROSS].neg[i] = n[2*CW+2];
      pipe_d[ST_CROSS].mag[i] = NW'(a);
      o = o | NW'(a);
    end
    pipe_d[ST_CROSS].orw = o;
    pipe_d[ST_CROSS].deg = (o == '0);
  end

  // leading-zero normalize, one power-of-two step per stage
  for (genvar j = 0; j < NL; j++) begin : g_norm
    localparam int unsigned SH = 1 << (NL - 1 - j);
    always_comb begin
      pipe_t pr;
      pr = pipe_q[ST_NORM+j-1];
      pipe_d[ST_NORM+j] = pr;
      if (pr.orw[NW-1 -: SH] == '0) begin
        for (int i = 0; i < 3; i++) begin
          pipe_d[ST_NORM+j].mag[i] = pr.mag[i] << SH;
        end
        pipe_d[ST_NORM+j].orw = pr.orw << SH;
      end
    end
  end

  always_comb begin
    pipe_t pr;
    logic [NORM_BITS-1:0] m;
    pr = pipe_q[ST_SQ-1];
    pipe_d[ST_SQ] = pr;
    for (int i = 0; i < 3; i++) begin
      m = pr.mag[i][NW-1 -: NORM_BITS];
      pipe_d[ST_SQ].sq[i] = m * m;
    end
  end

  always_comb begin
    pipe_t pr;
    pr = pipe_q[ST_SUM-1];
    pipe_d[ST_SUM] = pr;
    pipe_d[ST_SUM].x = SQ_W'(pr.sq[0]) + SQ_W'(pr.sq[1]) + SQ_W'(pr.sq[2]);
    pipe_d[ST_SUM].r = '0;
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int unsigned K = SQRT_STEPS - 1 - j;
    localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (2*K);
    always_comb begin
      pipe_t pr;
      logic [SQ_W-1:0] t;
      pr = pipe_q[ST_SQRT+j-1];
      pipe_d[ST_SQRT+j] = pr;
      t = pr.r + BIT;
      if (pr.x >= t) begin
        pipe_d[ST_SQRT+j].x = pr.x - t;
        pipe_d[ST_SQRT+j].r = (pr.r >> 1) + BIT;
      end else begin
        pipe_d[ST_SQRT+j].r = pr.r >> 1;
      end
    end
  end

  // dividend = m << F plus half the root; upper part is already below the root
  always_comb begin
    pipe_t pr;
    logic [DW-1:0] num;
    pr = pipe_q[ST_DIV0-1];
    pipe_d[ST_DIV0] = pr;
    for (int i = 0; i < 3; i++) begin
      num = (DW'(pr.mag[i][NW-1 -: NORM_BITS]) << NF) + DW'(pr.r[RW-1:0] >> 1);
      pipe_d[ST_DIV0].rem[i]  = RW'(num[DW-1:QW]);
      pipe_d[ST_DIV0].nlow[i] = num[QW-1:0];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    always_comb begin
      pipe_t pr;
      logic [RW:0] t;
      logic [RW:0] rr;
      pr = pipe_q[ST_DIV+j-1];
      pipe_d[ST_DIV+j] = pr;
      rr = (RW+1)'(pr.r[RW-1:0]);
      for (int i = 0; i < 3; i++) begin
        t = {pr.rem[i], pr.nlow[i][QW-1]};
        if (t >= rr) begin
          pipe_d[ST_DIV+j].rem[i]  = RW'(t - rr);
          pipe_d[ST_DIV+j].nlow[i] = {pr.nlow[i][QW-2:0], 1'b1};
        end else begin
          pipe_d[ST_DIV+j].rem[i]  = RW'(t);
          pipe_d[ST_DIV+j].nlow[i] = {pr.nlow[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  localparam logic [QW-1:0] LIM = {{(QW-1){1'b0}}, 1'b1} << NF;

  always_comb begin
    pipe_t pr;
    logic [QW-1:0] c;
    pr = pipe_q[ST_CLAMP-1];
    pipe_d[ST_CLAMP] = pr;
    for (int i = 0; i < 3; i++) begin
      c = (pr.nlow[i] > LIM) ? LIM : pr.nlow[i];
      if (pr.deg) begin
        pipe_d[ST_CLAMP].nu[i] = '0;
      end else begin
        pipe_d[ST_CLAMP].nu[i] = pr.neg[i] ? -c : c;
      end
    end
  end

  always_comb begin
    pipe_t pr;
    pr = pipe_q[ST_OPROD-1];
    pipe_d[ST_OPROD] = pr;
    for (int i = 0; i < 3; i++) begin
      pipe_d[ST_OPROD].prod[i] = $signed(pr.nu[i]) * $signed(pr.p3[i]);
    end
  end

  always_comb begin
    pipe_t pr;
    logic signed [AW-1:0] s;
    pr = pipe_q[ST_OSUM-1];
    pipe_d[ST_OSUM] = pr;
    s = $signed(pr.prod[0]) + $signed(pr.prod[1]) + $signed(pr.prod[2]);
    pipe_d[ST_OSUM].acc = -s;
  end

  localparam logic [EW-1:0] HALF = {{(EW-1){1'b0}}, 1'b1} << (NF - 1);
  localparam logic [EW-1:0] MAXP = {{(EW-OW+1){1'b0}}, {(OW-1){1'b1}}};

  // round half up on the magnitude, then saturate
  always_comb begin
    pipe_t pr;
    logic          sgn;
    logic [AW-1:0] a;
    logic [EW-1:0] am;
    pr = pipe_q[ST_FIN-1];
    pipe_d[ST_FIN] = pr;
    sgn = pr.acc[AW-1];
    a   = sgn ? -pr.acc : pr.acc;
    am  = (EW'(a) + HALF) >> NF;
    if (sgn) begin
      if (am > MAXP + 1'b1) begin
        am = MAXP + 1'b1;
      end
      am = -am;
    end else if (am > MAXP) begin
      am = MAXP;
    end
    pipe_d[ST_FIN].off = pr.deg ? '0 : OW'(am);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign last_word = {pipe_q[ST_FIN].deg,
                      OTW'({pipe_q[ST_FIN].off, pipe_q[ST_FIN].nu[2],
                            pipe_q[ST_FIN].nu[1], pipe_q[ST_FIN].nu[0]})};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vq <= 1'b0;
    end else if (skid_vq) begin
      if (m_axis_tready_i) begin
        skid_vq <= 1'b0;
      end
    end else if (vld_q[ST_FIN] && !m_axis_tready_i) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vq && vld_q[ST_FIN] && !m_axis_tready_i) begin
      skid_q <= last_word;
    end
  end

  assign m_axis_tvalid_o = skid_vq | vld_q[ST_FIN];
  assign m_axis_tdata_o  = skid_vq ? skid_q[OTW-1:0] : last_word[OTW-1:0];
  assign m_axis_tuser_o  = skid_vq ? skid_q[OTW] : last_word[OTW];

`ifndef ASSERT_OFF
  // collinear points give an all-zero result
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("degenerate result with nonzero data");

  // a stalled result moves into the skid register
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_vq && vld_q[ST_FIN] && !m_axis_tready_i) |=> skid_vq)
    else $error("stalled result not caught");

  // the pipeline is frozen while the skid register holds a result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vq |=> (vld_q == $past(vld_q)))
    else $error("pipeline moved while skid full");

  // the x component of the unit normal never exceeds one
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_CLAMP] |-> (pipe_q[ST_CLAMP].nu[0][NWD-1] ||
                         pipe_q[ST_CLAMP].nu[0][NWD-2:0] <= LIM[NWD-2:0]))
    else $error("normal x out of range");
`endif

endmodule
